// ===== design/dpas_pkg.sv =====
package dpas_pkg;

	localparam int MAX_TERMS_DEF   = 32;
	localparam int COEFF_WIDTH_DEF = 32;

	// Field widths of the channels
	localparam int MODE_W   = 3;
	localparam int IN_DEG_W = 5;
	localparam int DEG_W    = 6;
	localparam int FIELD_W  = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_SET_FIRST  = 3'd0,
		MODE_SET_SECOND = 3'd1,
		MODE_ADD        = 3'd2,
		MODE_SUB        = 3'd3,
		MODE_MUL        = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} ctrl_state_t;

	// Tag that travels alongside each pair of memory reads
	typedef struct packed {
		logic             issue;
		logic             first;
		logic             last_mac;
		logic             sub;
		logic             mul;
		logic             last_term;
		logic [DEG_W-1:0] degree;
	} mac_ctl_t;

endpackage

// ===== design/dpas_cmd_if.sv =====
interface dpas_cmd_if;
	logic                               valid;
	logic                               ready;
	logic        [dpas_pkg::MODE_W-1:0]   mode;
	logic        [dpas_pkg::IN_DEG_W-1:0] degree;
	logic signed [dpas_pkg::FIELD_W-1:0]  coeff_value;

	modport source (output valid, output mode, output degree, output coeff_value, input ready);
	modport sink   (input valid, input mode, input degree, input coeff_value, output ready);
endinterface

// ===== design/dpas_term_if.sv =====
interface dpas_term_if;
	logic                              valid;
	logic                              ready;
	logic        [dpas_pkg::DEG_W-1:0]   term_degree;
	logic signed [dpas_pkg::FIELD_W-1:0] term_coeff;
	logic                              last_term;

	modport source (output valid, output term_degree, output term_coeff, output last_term,
		input ready);
	modport sink   (input valid, input term_degree, input term_coeff, input last_term,
		output ready);
endinterface

// ===== design/dpas_coeff_mem.sv =====
module dpas_coeff_mem #(
	parameter int DEPTH = dpas_pkg::MAX_TERMS_DEF,
	parameter int WIDTH = dpas_pkg::COEFF_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	// An entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== design/dpas_mac.sv =====
module dpas_mac #(
	parameter int COEFF_WIDTH = dpas_pkg::COEFF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dpas_pkg::mac_ctl_t           ctl,
	input  logic [COEFF_WIDTH-1:0]       rdata_a,
	input  logic [COEFF_WIDTH-1:0]       rdata_b,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [dpas_pkg::DEG_W-1:0]   out_degree,
	output logic [COEFF_WIDTH-1:0]       out_coeff,
	output logic                         out_last
);

	dpas_pkg::mac_ctl_t     ctl_s1, ctl_s2;
	logic [COEFF_WIDTH-1:0] val_s2;
	logic [COEFF_WIDTH-1:0] acc_q;
	logic [COEFF_WIDTH-1:0] sum;
	logic [COEFF_WIDTH-1:0] val_d;
	logic                   out_valid_q;
	logic [dpas_pkg::DEG_W-1:0] out_degree_q;
	logic [COEFF_WIDTH-1:0] out_coeff_q;
	logic                   out_last_q;

	always_comb begin
		if (ctl_s1.mul) begin
			val_d = COEFF_WIDTH'(rdata_a * rdata_b);
		end else if (ctl_s1.sub) begin
			val_d = rdata_a - rdata_b;
		end else begin
			val_d = rdata_a + rdata_b;
		end
	end

	assign sum = (ctl_s2.first ? '0 : acc_q) + val_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			if (ctl_s2.issue && ctl_s2.last_mac) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_s2 <= val_d;
		if (ctl_s2.issue) begin
			acc_q <= sum;
			if (ctl_s2.last_mac) begin
				out_coeff_q  <= sum;
				out_degree_q <= ctl_s2.degree;
				out_last_q   <= ctl_s2.last_term;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_degree = out_degree_q;
	assign out_coeff  = out_coeff_q;
	assign out_last   = out_last_q;

endmodule

// ===== design/dpas_ctrl.sv =====
module dpas_ctrl #(
	parameter int MAX_TERMS = dpas_pkg::MAX_TERMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  logic [dpas_pkg::MODE_W-1:0]     mode,
	input  logic [dpas_pkg::IN_DEG_W-1:0]   degree,
	input  logic                            term_done,
	output logic                            wr_first,
	output logic                            wr_second,
	output logic [$clog2(MAX_TERMS)-1:0]    wr_addr,
	output logic                            rd_en,
	output logic [$clog2(MAX_TERMS)-1:0]    rd_addr_a,
	output logic [$clog2(MAX_TERMS)-1:0]    rd_addr_b,
	output dpas_pkg::mac_ctl_t              ctl
);

	localparam int AW = $clog2(MAX_TERMS);
	localparam int LW = $clog2(MAX_TERMS + 1);
	localparam int DW = dpas_pkg::DEG_W;
	localparam int EW = DW + 1;

	dpas_pkg::ctrl_state_t state_q, state_d;

	logic [LW-1:0] len_a_q, len_b_q;
	logic          op_mul_q, op_sub_q;
	logic [DW-1:0] k_q, n_q;
	logic [AW-1:0] i_q, hi_q;
	logic          first_q;

	logic          start, next_term, last_mac;
	logic          deg_ok;
	logic [LW-1:0] deg_p1;
	logic [EW-1:0] la_e, lb_e, k_nx_e, lo_e, hi_e, n_e;
	logic          op_mul_nx;
	dpas_pkg::mode_t mode_c;

	assign mode_c  = dpas_pkg::mode_t'(mode);
	assign deg_ok  = DW'(degree) < DW'(MAX_TERMS);
	assign deg_p1  = LW'(degree) + LW'(1);
	assign wr_addr = AW'(degree);
	assign la_e    = EW'(len_a_q);
	assign lb_e    = EW'(len_b_q);
	assign last_mac = (i_q == hi_q);

	// Length of the result about to start
	always_comb begin
		if (mode_c == dpas_pkg::MODE_MUL) begin
			n_e = la_e + lb_e - EW'(1);
		end else begin
			n_e = (la_e > lb_e) ? la_e : lb_e;
		end
	end

	// Index range of the next term: lo..hi over the first polynomial
	always_comb begin
		op_mul_nx = start ? (mode_c == dpas_pkg::MODE_MUL) : op_mul_q;
		k_nx_e    = start ? '0 : EW'(k_q) + EW'(1);
		if (op_mul_nx) begin
			lo_e = (k_nx_e + EW'(1) > lb_e) ? k_nx_e + EW'(1) - lb_e : '0;
			hi_e = (k_nx_e < la_e) ? k_nx_e : la_e - EW'(1);
		end else begin
			lo_e = k_nx_e;
			hi_e = k_nx_e;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		wr_first  = 1'b0;
		wr_second = 1'b0;
		start     = 1'b0;
		next_term = 1'b0;
		rd_en     = 1'b0;
		ctl       = '0;
		unique case (state_q)
			dpas_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (mode_c)
						dpas_pkg::MODE_SET_FIRST:  wr_first  = deg_ok;
						dpas_pkg::MODE_SET_SECOND: wr_second = deg_ok;
						dpas_pkg::MODE_ADD,
						dpas_pkg::MODE_SUB,
						dpas_pkg::MODE_MUL: begin
							start   = 1'b1;
							state_d = dpas_pkg::ST_ISSUE;
						end
						default: ;
					endcase
				end
			end
			dpas_pkg::ST_ISSUE: begin
				rd_en         = 1'b1;
				ctl.issue     = 1'b1;
				ctl.first     = first_q;
				ctl.last_mac  = last_mac;
				ctl.sub       = op_sub_q;
				ctl.mul       = op_mul_q;
				ctl.degree    = k_q;
				ctl.last_term = (EW'(k_q) + EW'(1)) == EW'(n_q);
				if (last_mac) begin
					state_d = dpas_pkg::ST_WAIT;
				end
			end
			dpas_pkg::ST_WAIT: begin
				if (term_done) begin
					if ((EW'(k_q) + EW'(1)) == EW'(n_q)) begin
						state_d = dpas_pkg::ST_IDLE;
					end else begin
						next_term = 1'b1;
						state_d   = dpas_pkg::ST_ISSUE;
					end
				end
			end
			default: state_d = dpas_pkg::ST_IDLE;
		endcase
	end

	assign rd_addr_a = i_q;
	assign rd_addr_b = op_mul_q ? AW'(k_q - DW'(i_q)) : i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q  <= LW'(1);
			len_b_q  <= LW'(1);
			op_mul_q <= 1'b0;
			op_sub_q <= 1'b0;
			k_q      <= '0;
			n_q      <= '0;
			i_q      <= '0;
			hi_q     <= '0;
			first_q  <= 1'b0;
		end else begin
			if (wr_first && deg_p1 > len_a_q) begin
				len_a_q <= deg_p1;
			end
			if (wr_second && deg_p1 > len_b_q) begin
				len_b_q <= deg_p1;
			end
			if (start) begin
				op_mul_q <= (mode_c == dpas_pkg::MODE_MUL);
				op_sub_q <= (mode_c == dpas_pkg::MODE_SUB);
				n_q      <= DW'(n_e);
			end
			if (start || next_term) begin
				k_q     <= DW'(k_nx_e);
				i_q     <= AW'(lo_e);
				hi_q    <= AW'(hi_e);
				first_q <= 1'b1;
			end else if (state_q == dpas_pkg::ST_ISSUE) begin
				first_q <= 1'b0;
				if (!last_mac) begin
					i_q <= i_q + AW'(1);
				end
			end
		end
	end

endmodule

// ===== design/dense_polynomial_add_sub_mul.sv =====
// Channel | Dir | Fields                                  | Transfer
// --------+-----+-----------------------------------------+------------------------
// cmd     | in  | mode, degree, coeff_value               | valid & ready, rising clk
// term    | out | term_degree, term_coeff, last_term      | valid & ready, rising clk
//
// A set item writes one stored coefficient. A compute item streams terms, one per
// result degree: max(lenA,lenB) terms for add/subtract and lenA+lenB-1 for multiply.
// Each term is issued only after the previous one has been transferred, its pace
// set by the single read port of each coefficient memory feeding one shared MAC.
// Reset (arst_n low) returns both lengths to 1 and marks every stored entry as zero.
// A stalled term holds the sequencer; no new command is taken until the last term
// has been transferred.
module dense_polynomial_add_sub_mul #(
	parameter int MAX_TERMS   = dpas_pkg::MAX_TERMS_DEF,
	parameter int COEFF_WIDTH = dpas_pkg::COEFF_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	dpas_cmd_if.sink            cmd,
	dpas_term_if.source         term
);

	localparam int AW = $clog2(MAX_TERMS);
	localparam int FW = dpas_pkg::FIELD_W;

	logic                   wr_first, wr_second, rd_en, term_done;
	logic [AW-1:0]          wr_addr, rd_addr_a, rd_addr_b;
	logic [COEFF_WIDTH-1:0] wdata, rdata_a, rdata_b, out_coeff;
	dpas_pkg::mac_ctl_t     ctl;

	// Wrap the incoming coefficient to the stored width
	assign wdata     = cmd.coeff_value[COEFF_WIDTH-1:0];
	// The sequencer waits on this before issuing the next term
	assign term_done = term.valid & term.ready;

	dpas_ctrl #(
		.MAX_TERMS(MAX_TERMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.mode      (cmd.mode),
		.degree    (cmd.degree),
		.term_done (term_done),
		.wr_first  (wr_first),
		.wr_second (wr_second),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.ctl       (ctl)
	);

	// First polynomial store
	dpas_coeff_mem #(
		.DEPTH(MAX_TERMS),
		.WIDTH(COEFF_WIDTH)
	) u_mem_a (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr_first),
		.waddr  (wr_addr),
		.wdata  (wdata),
		.re     (rd_en),
		.raddr  (rd_addr_a),
		.rdata  (rdata_a)
	);

	// Second polynomial store
	dpas_coeff_mem #(
		.DEPTH(MAX_TERMS),
		.WIDTH(COEFF_WIDTH)
	) u_mem_b (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr_second),
		.waddr  (wr_addr),
		.wdata  (wdata),
		.re     (rd_en),
		.raddr  (rd_addr_b),
		.rdata  (rdata_b)
	);

	dpas_mac #(
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b),
		.out_ready  (term.ready),
		.out_valid  (term.valid),
		.out_degree (term.term_degree),
		.out_coeff  (out_coeff),
		.out_last   (term.last_term)
	);

	// Sign-extend the wrapped coefficient to the field width
	assign term.term_coeff = FW'($signed(out_coeff));

endmodule
